// ----- hdl/tsjq_pkg.sv -----
// Shared types and constants of the tetrahedron scaled jacobian quality block.
// Holds the request and result structs, field widths and the pipeline latencies.
// No dependencies.
package tsjq_pkg;

  localparam int COORD_W = 32;
  localparam int UNIT_W  = 30;
  localparam int LIMIT_W = 15;
  localparam int QUAL_W  = 16;

  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = 30;
  localparam int QDIV_STEPS = 16;

  // Edge unit: five front stages, the root, one setup stage, the divide, one output stage.
  localparam int EDGE_LAT   = 7 + SQRT_STEPS + UDIV_STEPS;
  // Corner unit: four product stages, one setup stage, the divide, one output stage.
  localparam int CORNER_LAT = 6 + QDIV_STEPS;
  localparam int TOTAL_LAT  = EDGE_LAT + CORNER_LAT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic signed [QUAL_W-1:0]  qual_t;

  localparam limit_t LIMIT_RESET = 15'd11585;
  localparam qual_t  QUAL_MAX    = 16'sh7FFF;
  localparam qual_t  QUAL_MIN    = 16'sh8000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } uvec_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t dx;
    coord_t dy;
    coord_t dz;
  } in_item_t;

  typedef struct packed {
    qual_t quality;
    logic  degenerate;
  } out_item_t;

endpackage

// ----- hdl/tsjq_unit_edge.sv -----
// Pipelined edge normalizer: difference of two corners, block scaling, integer
// square root and per-component restoring divide into a Q2.28 unit vector.
// Depends on tsjq_pkg.
module tsjq_unit_edge
  import tsjq_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  point_t p_from,
  input  point_t p_to,
  output uvec_t  unit_vec,
  output logic   zero_len
);

  localparam int DW     = COORD_W + 1;
  localparam int SM_W   = 31;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int SH_W   = 5;
  localparam int SIDE_N = SQRT_STEPS + 2;

  typedef struct packed {
    logic [2:0][SM_W-1:0] sm;
    logic [2:0]           neg;
    logic                 zero;
  } side_t;

  coord_t from_c [3];
  coord_t to_c   [3];

  assign from_c[0] = p_from.x;
  assign from_c[1] = p_from.y;
  assign from_c[2] = p_from.z;
  assign to_c[0]   = p_to.x;
  assign to_c[1]   = p_to.y;
  assign to_c[2]   = p_to.z;

  // Stage 1: exact differences.
  logic signed [DW-1:0] diff_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        diff_r[j] <= DW'(to_c[j]) - DW'(from_c[j]);
      end
    end
  end

  // Stage 2: magnitudes and the common scaling shift from the leading one.
  logic [DW-1:0]   mag_nxt [3];
  logic [DW-1:0]   mag_or;
  logic [SH_W-1:0] lsh_nxt;
  logic [1:0]      rsh_nxt;
  logic [DW-1:0]   mag_r [3];
  logic [2:0]      neg2_r;
  logic            zero2_r;
  logic [SH_W-1:0] lsh_r;
  logic [1:0]      rsh_r;

  always_comb begin
    mag_or  = '0;
    lsh_nxt = SH_W'(30);
    rsh_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      mag_nxt[j] = diff_r[j][DW-1] ? DW'(-diff_r[j]) : DW'(diff_r[j]);
      mag_or     = mag_or | mag_nxt[j];
    end
    for (int b = 0; b < DW; b++) begin
      if (mag_or[b]) begin
        if (b > 30) begin
          rsh_nxt = 2'(b - 30);
          lsh_nxt = '0;
        end else begin
          lsh_nxt = SH_W'(30 - b);
          rsh_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag_r[j]  <= mag_nxt[j];
        neg2_r[j] <= diff_r[j][DW-1];
      end
      zero2_r <= (mag_or == '0);
      lsh_r   <= lsh_nxt;
      rsh_r   <= rsh_nxt;
    end
  end

  // Stage 3: apply the shift so the largest magnitude lies in [2^30, 2^31).
  side_t       side3_nxt;
  side_t       side3_r;
  logic [63:0] shifted;

  always_comb begin
    shifted   = '0;
    side3_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      shifted          = ({31'b0, mag_r[j]} << lsh_r) >> rsh_r;
      side3_nxt.sm[j]  = shifted[SM_W-1:0];
    end
    side3_nxt.neg  = neg2_r;
    side3_nxt.zero = zero2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side3_nxt;
    end
  end

  // Stage 4: squares. Stage 5: sum of squares.
  logic [61:0] sq_r [3];
  logic [63:0] sum_r;
  side_t       side_d_r [SIDE_N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= 62'(side3_r.sm[j]) * 62'(side3_r.sm[j]);
      end
      sum_r       <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      side_d_r[0] <= side3_r;
      for (int i = 1; i < SIDE_N; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  // Integer square root, one result bit per stage.
  logic [63:0]       sx_r    [SQRT_STEPS];
  logic [REM_W-1:0]  srem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] sroot_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [63:0]       x_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign x_in    = sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = sx_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
    end

    assign rem_sh = {rem_in, x_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k] <= {x_in[61:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_r[k]  <= REM_W'(rem_sh - trial);
          sroot_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r[k]  <= rem_sh[REM_W-1:0];
          sroot_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Divide setup: numerator is mag * 2^28 + len / 2; the quotient fits 30 bits.
  logic [ROOT_W-1:0] len;
  side_t             side_last;
  logic [59:0]       num_full [3];

  assign len       = sroot_r[SQRT_STEPS-1];
  assign side_last = side_d_r[SIDE_N-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_full[j] = {1'b0, side_last.sm[j], 28'b0} + 60'(len >> 1);
    end
  end

  logic [ROOT_W-1:0] dr_r    [UDIV_STEPS+1][3];
  logic [UNIT_W-1:0] dn_r    [UDIV_STEPS+1][3];
  logic [ROOT_W-1:0] dlen_r  [UDIV_STEPS+1];
  logic [2:0]        dneg_r  [UDIV_STEPS+1];
  logic              dzero_r [UDIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dr_r[0][j] <= ROOT_W'(num_full[j][59:30]);
        dn_r[0][j] <= num_full[j][29:0];
      end
      dlen_r[0]  <= len;
      dneg_r[0]  <= side_last.neg;
      dzero_r[0] <= side_last.zero;
    end
  end

  for (genvar k = 1; k <= UDIV_STEPS; k++) begin : g_udiv
    logic [ROOT_W:0] rem2 [3];
    logic [2:0]      ge;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem2[j] = {dr_r[k-1][j], dn_r[k-1][j][UNIT_W-1]};
        ge[j]   = (rem2[j] >= {1'b0, dlen_r[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          dr_r[k][j] <= ge[j] ? ROOT_W'(rem2[j] - {1'b0, dlen_r[k-1]}) : rem2[j][ROOT_W-1:0];
          dn_r[k][j] <= {dn_r[k-1][j][UNIT_W-2:0], ge[j]};
        end
        dlen_r[k]  <= dlen_r[k-1];
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
      end
    end
  end

  // Output: reapply the component signs.
  unit_t comp_nxt [3];
  uvec_t unit_vec_r;
  logic  zero_len_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      comp_nxt[j] = dneg_r[UDIV_STEPS][j] ? -$signed(dn_r[UDIV_STEPS][j])
                                          : $signed(dn_r[UDIV_STEPS][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_vec_r <= '{x: comp_nxt[0], y: comp_nxt[1], z: comp_nxt[2]};
      zero_len_r <= dzero_r[UDIV_STEPS];
    end
  end

  assign unit_vec = unit_vec_r;
  assign zero_len = zero_len_r;

endmodule

// ----- hdl/tsjq_corner.sv -----
// Pipelined corner quality: cross and triple product of three unit edges, then
// the bend-point mapping with a restoring divide by the limit, saturated to Q2.14.
// Depends on tsjq_pkg.
module tsjq_corner
  import tsjq_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  uvec_t  ua,
  input  uvec_t  ub,
  input  uvec_t  uc,
  input  limit_t limit,
  output qual_t  quality
);

  localparam int PW   = 2 * UNIT_W;
  localparam int CR_W = UNIT_W + 1;
  localparam int TW   = UNIT_W + CR_W;
  localparam int T_W  = 36;

  localparam logic signed [PW:0] CR_HALF = (PW+1)'(1) <<< 27;
  localparam logic signed [63:0] ONE56   = 64'sd1 <<< 56;
  localparam logic signed [63:0] HALF42  = 64'sd1 <<< 41;
  localparam logic signed [63:0] SAT_HI  = 64'sd32767;
  localparam logic signed [63:0] SAT_LO  = -64'sd32768;

  // Stage 1: the six cross-product terms.
  logic signed [PW-1:0] prod_r [6];
  uvec_t                ua1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= PW'(ub.y) * PW'(uc.z);
      prod_r[1] <= PW'(ub.z) * PW'(uc.y);
      prod_r[2] <= PW'(ub.z) * PW'(uc.x);
      prod_r[3] <= PW'(ub.x) * PW'(uc.z);
      prod_r[4] <= PW'(ub.x) * PW'(uc.y);
      prod_r[5] <= PW'(ub.y) * PW'(uc.x);
      ua1_r     <= ua;
    end
  end

  // Stage 2: cross product rounded back to Q2.28, half away from zero.
  logic signed [PW:0]     cd     [3];
  logic signed [PW:0]     cr_tmp [3];
  logic signed [CR_W-1:0] cr_r   [3];
  uvec_t                  ua2_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cd[j]     = (PW+1)'(prod_r[2*j]) - (PW+1)'(prod_r[2*j+1]);
      cr_tmp[j] = (cd[j] + CR_HALF - $signed({{PW{1'b0}}, cd[j][PW]})) >>> 28;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        cr_r[j] <= CR_W'(cr_tmp[j]);
      end
      ua2_r <= ua1_r;
    end
  end

  // Stage 3: triple product terms. Stage 4: their exact sum in Q4.56.
  logic signed [TW-1:0] tp_r [3];
  logic signed [63:0]   v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r[0] <= TW'(ua2_r.x) * TW'(cr_r[0]);
      tp_r[1] <= TW'(ua2_r.y) * TW'(cr_r[1]);
      tp_r[2] <= TW'(ua2_r.z) * TW'(cr_r[2]);
      v_r     <= 64'(tp_r[0]) + 64'(tp_r[1]) + 64'(tp_r[2]);
    end
  end

  // Stage 5: pick the branch, finish the upper branch, prepare the divide.
  logic signed [63:0] c56;
  logic signed [63:0] n_hi;
  logic signed [63:0] r_hi;
  logic               hi_nxt;
  qual_t              qa_nxt;
  logic [63:0]        vmag;
  logic [63:0]        tsum;
  logic [T_W-1:0]     t_nxt;
  logic               ovf_nxt;

  always_comb begin
    c56    = $signed({7'b0, limit, 42'b0});
    hi_nxt = (v_r > c56);
    n_hi   = ONE56 + c56 - v_r;
    r_hi   = (n_hi + HALF42 - $signed({63'b0, n_hi[63]})) >>> 42;
    if (r_hi > SAT_HI) begin
      qa_nxt = QUAL_MAX;
    end else if (r_hi < SAT_LO) begin
      qa_nxt = QUAL_MIN;
    end else begin
      qa_nxt = QUAL_W'(r_hi);
    end
    vmag    = v_r[63] ? 64'(-v_r) : 64'(v_r);
    tsum    = vmag + 64'({limit, 27'b0});
    t_nxt   = T_W'(tsum >> 28);
    ovf_nxt = (t_nxt >= T_W'({limit, 16'b0}));
  end

  logic [LIMIT_W-1:0] qr_r   [QDIV_STEPS+1];
  logic [QUAL_W-1:0]  qn_r   [QDIV_STEPS+1];
  logic               hi_r   [QDIV_STEPS+1];
  qual_t              qa_r   [QDIV_STEPS+1];
  logic               negv_r [QDIV_STEPS+1];
  logic               ovf_r  [QDIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r[0]   <= t_nxt[LIMIT_W+15:16];
      qn_r[0]   <= t_nxt[15:0];
      hi_r[0]   <= hi_nxt;
      qa_r[0]   <= qa_nxt;
      negv_r[0] <= v_r[63];
      ovf_r[0]  <= ovf_nxt;
    end
  end

  for (genvar k = 1; k <= QDIV_STEPS; k++) begin : g_qdiv
    logic [LIMIT_W:0] rem2;
    logic             ge;

    assign rem2 = {qr_r[k-1], qn_r[k-1][QUAL_W-1]};
    assign ge   = (rem2 >= {1'b0, limit});

    always_ff @(posedge clk) begin
      if (en) begin
        qr_r[k]   <= ge ? LIMIT_W'(rem2 - {1'b0, limit}) : rem2[LIMIT_W-1:0];
        qn_r[k]   <= {qn_r[k-1][QUAL_W-2:0], ge};
        hi_r[k]   <= hi_r[k-1];
        qa_r[k]   <= qa_r[k-1];
        negv_r[k] <= negv_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
      end
    end
  end

  // Output: pass the upper branch through, or apply sign and saturation to the lower branch.
  logic [QUAL_W-1:0] quot;
  qual_t             q_nxt;
  qual_t             quality_r;

  always_comb begin
    quot = qn_r[QDIV_STEPS];
    if (hi_r[QDIV_STEPS]) begin
      q_nxt = qa_r[QDIV_STEPS];
    end else if (negv_r[QDIV_STEPS]) begin
      if (ovf_r[QDIV_STEPS] || (quot > 16'd32768)) begin
        q_nxt = QUAL_MIN;
      end else begin
        q_nxt = QUAL_W'(-$signed({1'b0, quot}));
      end
    end else begin
      if (ovf_r[QDIV_STEPS] || (quot > 16'd32767)) begin
        q_nxt = QUAL_MAX;
      end else begin
        q_nxt = $signed(quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quality_r <= q_nxt;
    end
  end

  assign quality = quality_r;

endmodule

// ----- hdl/tetra_scaled_jacobian_quality.sv -----
// Top level of the tetrahedron scaled jacobian quality block.
// Depends on tsjq_pkg, tsjq_unit_edge and tsjq_corner.
//
// Usage:
//   A request carries the four corners of one tetrahedron as signed Q16.16
//   coordinates. It is taken at a rising edge where in_valid is high and
//   in_stall is low. Each request yields exactly one result: the minimum
//   scaled jacobian over the four corners in signed Q2.14, plus a flag that
//   is set when some edge has zero length (the quality is then zero).
//   The bend point is written through cfg_we / cfg_wdata; a written zero acts
//   as one. Write it only while no request is in flight.
//
// Timing:
//   A request passes through the edge normalizers (dominated by the 32-step
//   square root and the 30-step unit divide), then the corner units
//   (dominated by the 16-step divide by the bend point) and then the minimum.
//   One request is taken every cycle while in_stall is low.
//   Reset clears every valid bit and loads the default bend point.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
module tetra_scaled_jacobian_quality
  import tsjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  limit_t    cfg_wdata
);

  // Bend point register; a zero is treated as one downstream.
  limit_t limit_r;
  limit_t limit_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign limit_eff = (limit_r == '0) ? limit_t'(1) : limit_r;

  // The pipeline advances unless the output holds a result the receiver refuses.
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  point_t pa, pb, pc, pd;

  assign pa = '{x: in_item.ax, y: in_item.ay,       z: in_item.az};
  assign pb = '{x: in_item.bx, y: in_item.by_coord, z: in_item.bz};
  assign pc = '{x: in_item.cx, y: in_item.cy,       z: in_item.cz};
  assign pd = '{x: in_item.dx, y: in_item.dy,       z: in_item.dz};

  // Six distinct edges. Reversing an edge only flips the sign of its unit
  // vector, because scaling and rounding act on magnitudes.
  uvec_t u01, u02, u03, u12, u13, u23;
  logic  z01, z02, z03, z12, z13, z23;

  tsjq_unit_edge u_e01 (.clk, .en, .p_from(pa), .p_to(pb), .unit_vec(u01), .zero_len(z01));
  tsjq_unit_edge u_e02 (.clk, .en, .p_from(pa), .p_to(pc), .unit_vec(u02), .zero_len(z02));
  tsjq_unit_edge u_e03 (.clk, .en, .p_from(pa), .p_to(pd), .unit_vec(u03), .zero_len(z03));
  tsjq_unit_edge u_e12 (.clk, .en, .p_from(pb), .p_to(pc), .unit_vec(u12), .zero_len(z12));
  tsjq_unit_edge u_e13 (.clk, .en, .p_from(pb), .p_to(pd), .unit_vec(u13), .zero_len(z13));
  tsjq_unit_edge u_e23 (.clk, .en, .p_from(pc), .p_to(pd), .unit_vec(u23), .zero_len(z23));

  function automatic uvec_t flip(input uvec_t v);
    flip = '{x: -v.x, y: -v.y, z: -v.z};
  endfunction

  // Corner orderings: corner 0 sees edges 01, 02, 03; corner 1 sees 10, 13, 12;
  // corner 2 sees 20, 21, 23; corner 3 sees 30, 32, 31.
  qual_t q0, q1, q2, q3;

  tsjq_corner u_k0 (.clk, .en, .ua(u01), .ub(u02), .uc(u03),
                    .limit(limit_eff), .quality(q0));
  tsjq_corner u_k1 (.clk, .en, .ua(flip(u01)), .ub(u13), .uc(u12),
                    .limit(limit_eff), .quality(q1));
  tsjq_corner u_k2 (.clk, .en, .ua(flip(u02)), .ub(flip(u12)), .uc(u23),
                    .limit(limit_eff), .quality(q2));
  tsjq_corner u_k3 (.clk, .en, .ua(flip(u03)), .ub(flip(u23)), .uc(flip(u13)),
                    .limit(limit_eff), .quality(q3));

  // The zero-length flag waits alongside the corner units.
  logic zd_r [CORNER_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      zd_r[0] <= z01 | z02 | z03 | z12 | z13 | z23;
      for (int i = 1; i < CORNER_LAT; i++) begin
        zd_r[i] <= zd_r[i-1];
      end
    end
  end

  // Valid bits travel with the data through every stage.
  logic vld_r [TOTAL_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_valid_r = vld_r[TOTAL_LAT-1];

  // Final stage: minimum over the corners, forced to zero for a degenerate shape.
  qual_t     m01, m23, qmin;
  out_item_t out_item_r;

  assign m01  = (q0 < q1) ? q0 : q1;
  assign m23  = (q2 < q3) ? q2 : q3;
  assign qmin = (m01 < m23) ? m01 : m23;

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.quality    <= zd_r[CORNER_LAT-1] ? qual_t'(0) : qmin;
      out_item_r.degenerate <= zd_r[CORNER_LAT-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A degenerate result always reports zero quality.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |-> out_item.quality == qual_t'(0))
    else $error("degenerate result with nonzero quality");

  // No corner mapping can exceed one in Q2.14.
  a_quality_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.quality <= 16'sd16384)
    else $error("quality above one");

  // An accepted request enters the first valid stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request lost at the pipeline entry");

endmodule
